@@ rtl/core/rtls_pkg.sv @@
`timescale 1ns / 1ps

package rtls_pkg;

  // Number of line sensors; black counts above this are clamped
  localparam logic [3:0] SensorCount = 4'd8;

  // Run modes
  localparam logic [2:0] ModeIdle     = 3'd0;
  localparam logic [2:0] ModeRunning  = 3'd1;
  localparam logic [2:0] ModeBraking  = 3'd2;
  localparam logic [2:0] ModeFinished = 3'd3;
  localparam logic [2:0] ModeFault    = 3'd4;

  // Motor drive actions
  localparam logic [1:0] DriveCoast   = 2'd0;
  localparam logic [1:0] DriveForward = 2'd1;
  localparam logic [1:0] DriveBrake   = 2'd2;

  // Indicator commands
  localparam logic [2:0] IndNone     = 3'd0;
  localparam logic [2:0] IndIdle     = 3'd1;
  localparam logic [2:0] IndStart    = 3'd2;
  localparam logic [2:0] IndFinished = 3'd3;
  localparam logic [2:0] IndFault    = 3'd4;

  // Configuration register indexes
  localparam logic [7:0] RegStartGuard   = 8'd0;
  localparam logic [7:0] RegMaxRun       = 8'd1;
  localparam logic [7:0] RegBrakeTime    = 8'd2;
  localparam logic [7:0] RegBlackMin     = 8'd3;
  localparam logic [7:0] RegBlackConfirm = 8'd4;
  localparam logic [7:0] RegControlPer   = 8'd5;
  localparam logic [7:0] RegSpeedPer     = 8'd6;
  localparam logic [7:0] RegBaseSpeed    = 8'd7;

  localparam logic [9:0]  MaxSpeed   = 10'd1000;
  localparam logic [23:0] RunTimeTop = 24'hFFFFFF;
  localparam logic [15:0] BlackTop   = 16'hFFFF;

  typedef struct packed {
    logic [15:0] start_guard_ms;
    logic [23:0] max_run_ms;
    logic [15:0] brake_time_ms;
    logic [3:0]  black_sensor_min;
    logic [15:0] black_confirm_ms;
    logic [7:0]  control_period_ms;
    logic [7:0]  speed_period_ms;
    logic [9:0]  base_speed_permille;
  } cfg_t;

  typedef struct packed {
    logic       button_pressed;
    logic       line_read_ok;
    logic [3:0] black_count;
  } in_word_t;

endpackage

@@ rtl/core/rtls_if.sv @@
`timescale 1ns / 1ps

// Input tick channel
interface rtls_in_if;
  logic       valid;
  logic       ready;
  logic       button_pressed;
  logic       line_read_ok;
  logic [3:0] black_count;

  modport source (output valid, button_pressed, line_read_ok, black_count, input ready);
  modport sink (input valid, button_pressed, line_read_ok, black_count, output ready);
endinterface

// Result channel
interface rtls_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] run_state;
  logic       motor_enabled;
  logic [1:0] motor_action;
  logic [9:0] drive_speed;
  logic       balance_reset;
  logic       balance_step;
  logic [2:0] indicator_cmd;

  modport source (output valid, run_state, motor_enabled, motor_action, drive_speed,
                  balance_reset, balance_step, indicator_cmd, input ready);
  modport sink (input valid, run_state, motor_enabled, motor_action, drive_speed,
                balance_reset, balance_step, indicator_cmd, output ready);
endinterface

// Configuration write channel
interface rtls_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/rtls_cfg_regs.sv @@
`timescale 1ns / 1ps

module rtls_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  rtls_cfg_if.sink       cfg_i,
  output rtls_pkg::cfg_t cfg_o
);

  rtls_pkg::cfg_t cfg_q;

  // Writes are always taken; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_guard_ms      <= 16'd500;
      cfg_q.max_run_ms          <= 24'd30000;
      cfg_q.brake_time_ms       <= 16'd300;
      cfg_q.black_sensor_min    <= 4'd3;
      cfg_q.black_confirm_ms    <= 16'd20;
      cfg_q.control_period_ms   <= 8'd5;
      cfg_q.speed_period_ms     <= 8'd10;
      cfg_q.base_speed_permille <= 10'd300;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        rtls_pkg::RegStartGuard:   cfg_q.start_guard_ms      <= cfg_i.data[15:0];
        rtls_pkg::RegMaxRun:       cfg_q.max_run_ms          <= cfg_i.data[23:0];
        rtls_pkg::RegBrakeTime:    cfg_q.brake_time_ms       <= cfg_i.data[15:0];
        rtls_pkg::RegBlackMin:     cfg_q.black_sensor_min    <= cfg_i.data[3:0];
        rtls_pkg::RegBlackConfirm: cfg_q.black_confirm_ms    <= cfg_i.data[15:0];
        rtls_pkg::RegControlPer:   cfg_q.control_period_ms   <= cfg_i.data[7:0];
        rtls_pkg::RegSpeedPer:     cfg_q.speed_period_ms     <= cfg_i.data[7:0];
        rtls_pkg::RegBaseSpeed:    cfg_q.base_speed_permille <= cfg_i.data[9:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/rtls_in_stage.sv @@
`timescale 1ns / 1ps

module rtls_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  rtls_in_if.sink            in_i,
  output logic               valid_o,
  output rtls_pkg::in_word_t word_o,
  input  logic               ready_i
);

  logic               valid_q, valid_d;
  rtls_pkg::in_word_t word_q;
  logic               take;

  // Stage is free when empty or when its word moves on this cycle
  assign in_i.ready = !valid_q || ready_i;
  assign take       = in_i.valid && in_i.ready;
  assign valid_d    = take ? 1'b1 : (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q <= '{button_pressed: in_i.button_pressed,
                  line_read_ok:   in_i.line_read_ok,
                  black_count:    in_i.black_count};
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

@@ rtl/core/rtls_seq.sv @@
`timescale 1ns / 1ps

module rtls_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rtls_pkg::cfg_t     cfg_i,
  input  logic               valid_i,
  input  rtls_pkg::in_word_t word_i,
  output logic               ready_o,
  rtls_out_if.source         out_o
);

  // Sequencer state
  logic [2:0]  mode_q, mode_d;
  logic [23:0] run_time_q, run_time_d;
  logic [15:0] black_time_q, black_time_d;
  logic [15:0] brake_left_q, brake_left_d;
  logic [7:0]  line_div_q, line_div_d;
  logic [7:0]  speed_div_q, speed_div_d;
  logic [1:0]  drive_q, drive_d;
  logic [9:0]  fwd_speed_q, fwd_speed_d;

  // Result register
  logic        out_valid_q;
  logic [2:0]  ind_q, ind_d;
  logic        bal_reset_q, bal_reset_d;
  logic        bal_step_q, bal_step_d;

  logic        fire;
  logic [3:0]  count;
  logic [16:0] black_sum;

  assign ready_o = !out_valid_q || out_o.ready;
  assign fire    = valid_i && ready_o;

  assign count = (word_i.black_count > rtls_pkg::SensorCount) ? rtls_pkg::SensorCount
                                                              : word_i.black_count;

  // One tick: button, run or brake timer, line check, speed strobe
  always_comb begin
    mode_d       = mode_q;
    run_time_d   = run_time_q;
    black_time_d = black_time_q;
    brake_left_d = brake_left_q;
    drive_d      = drive_q;
    fwd_speed_d  = fwd_speed_q;
    ind_d        = rtls_pkg::IndNone;
    bal_reset_d  = 1'b0;
    bal_step_d   = 1'b0;
    black_sum    = '0;
    line_div_d   = line_div_q + 8'd1;
    speed_div_d  = speed_div_q + 8'd1;

    // Button: stop an active run, otherwise start one
    if (word_i.button_pressed) begin
      if (mode_q == rtls_pkg::ModeRunning || mode_q == rtls_pkg::ModeBraking) begin
        drive_d = rtls_pkg::DriveCoast;
        mode_d  = rtls_pkg::ModeIdle;
        ind_d   = rtls_pkg::IndIdle;
      end else begin
        run_time_d   = '0;
        black_time_d = '0;
        bal_reset_d  = 1'b1;
        drive_d      = rtls_pkg::DriveForward;
        fwd_speed_d  = (cfg_i.base_speed_permille > rtls_pkg::MaxSpeed) ?
                       rtls_pkg::MaxSpeed : cfg_i.base_speed_permille;
        ind_d        = rtls_pkg::IndStart;
        mode_d       = rtls_pkg::ModeRunning;
      end
    end

    // Run timeout or brake countdown
    if (mode_d == rtls_pkg::ModeRunning) begin
      if (run_time_d != rtls_pkg::RunTimeTop) begin
        run_time_d = run_time_d + 24'd1;
      end
      if (run_time_d >= cfg_i.max_run_ms) begin
        drive_d = rtls_pkg::DriveCoast;
        mode_d  = rtls_pkg::ModeFault;
        ind_d   = rtls_pkg::IndFault;
      end
    end else if (mode_d == rtls_pkg::ModeBraking) begin
      if (brake_left_d != 16'd0) begin
        brake_left_d = brake_left_d - 16'd1;
      end
      if (brake_left_d == 16'd0) begin
        drive_d = rtls_pkg::DriveCoast;
        mode_d  = rtls_pkg::ModeFinished;
      end
    end

    // Line check once per control period
    if (line_div_d >= cfg_i.control_period_ms) begin
      line_div_d = '0;
      if (!word_i.line_read_ok) begin
        if (mode_d == rtls_pkg::ModeRunning) begin
          drive_d = rtls_pkg::DriveCoast;
          mode_d  = rtls_pkg::ModeFault;
          ind_d   = rtls_pkg::IndFault;
        end
      end else if (mode_d != rtls_pkg::ModeRunning ||
                   run_time_d < {8'd0, cfg_i.start_guard_ms}) begin
        black_time_d = '0;
      end else if (count >= cfg_i.black_sensor_min) begin
        // Confirm timer saturates at its top
        black_sum    = {1'b0, black_time_d} + {9'd0, cfg_i.control_period_ms};
        black_time_d = black_sum[16] ? rtls_pkg::BlackTop : black_sum[15:0];
        if (black_time_d >= cfg_i.black_confirm_ms) begin
          drive_d      = rtls_pkg::DriveBrake;
          brake_left_d = cfg_i.brake_time_ms;
          mode_d       = rtls_pkg::ModeBraking;
          ind_d        = rtls_pkg::IndFinished;
        end
      end else begin
        black_time_d = '0;
      end
    end

    // Balancer step strobe
    if (speed_div_d >= cfg_i.speed_period_ms) begin
      speed_div_d = '0;
      bal_step_d  = (mode_d == rtls_pkg::ModeRunning);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= rtls_pkg::ModeIdle;
      run_time_q   <= '0;
      black_time_q <= '0;
      brake_left_q <= '0;
      line_div_q   <= '0;
      speed_div_q  <= '0;
      drive_q      <= rtls_pkg::DriveCoast;
      fwd_speed_q  <= '0;
      out_valid_q  <= 1'b0;
      ind_q        <= rtls_pkg::IndNone;
      bal_reset_q  <= 1'b0;
      bal_step_q   <= 1'b0;
    end else begin
      if (fire) begin
        mode_q       <= mode_d;
        run_time_q   <= run_time_d;
        black_time_q <= black_time_d;
        brake_left_q <= brake_left_d;
        line_div_q   <= line_div_d;
        speed_div_q  <= speed_div_d;
        drive_q      <= drive_d;
        fwd_speed_q  <= fwd_speed_d;
        ind_q        <= ind_d;
        bal_reset_q  <= bal_reset_d;
        bal_step_q   <= bal_step_d;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word is the state after the tick plus its strobes
  assign out_o.valid         = out_valid_q;
  assign out_o.run_state     = mode_q;
  assign out_o.motor_enabled = (drive_q != rtls_pkg::DriveCoast);
  assign out_o.motor_action  = drive_q;
  assign out_o.drive_speed   = (drive_q == rtls_pkg::DriveForward) ? fwd_speed_q : 10'd0;
  assign out_o.balance_reset = bal_reset_q;
  assign out_o.balance_step  = bal_step_q;
  assign out_o.indicator_cmd = ind_q;

endmodule

@@ rtl/core/run_to_line_sequencer_top.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Word
// in_i     in   valid/ready   button_pressed, line_read_ok, black_count
// out_o    out  valid/ready   run_state, motor_enabled, motor_action, drive_speed,
//                             balance_reset, balance_step, indicator_cmd
// cfg_i    in   valid/ready   index (8 bits), data (24 bits); ready always high
//
// Input accept to result valid: input register, then the sequencer logic into the
// result register. One tick per cycle is sustained unless the output stalls.
// The result register updates the sequencer state in the same cycle, so a stalled
// output holds both the result and the state; the input register keeps one more tick.
// Reset clears the mode, timers, dividers and drive; registers come up at defaults.

module run_to_line_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtls_in_if.sink     in_i,
  rtls_out_if.source  out_o,
  rtls_cfg_if.sink    cfg_i
);

  rtls_pkg::cfg_t     cfg;
  rtls_pkg::in_word_t word;
  logic               word_valid;
  logic               word_ready;

  // Configuration registers
  rtls_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input tick register
  rtls_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (word_valid),
    .word_o  (word),
    .ready_i (word_ready)
  );

  // Mode logic and result register
  rtls_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (word_valid),
    .word_i  (word),
    .ready_o (word_ready),
    .out_o   (out_o)
  );

endmodule

@@ sim/run_to_line_sequencer_top_tb.sv @@
`timescale 1ns / 1ps

module run_to_line_sequencer_top_tb;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 6;   // input and result registers plus margin
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned PhaseTicks   = 40;
  localparam int unsigned PhaseCount   = 8;
  localparam logic [7:0]  RegPastEnd   = 8'd8;  // no register here, write must be dropped

  typedef enum logic [1:0] {OpTick, OpRegWrite, OpSettle} op_kind_e;

  typedef struct {
    op_kind_e           kind;
    rtls_pkg::in_word_t word;
    logic [7:0]         index;
    logic [23:0]        data;
    int unsigned        gap;
  } pending_op_t;

  typedef struct packed {
    logic [2:0] run_state;
    logic       motor_enabled;
    logic [1:0] motor_action;
    logic [9:0] drive_speed;
    logic       balance_reset;
    logic       balance_step;
    logic [2:0] indicator_cmd;
  } tick_result_t;

  logic clk_i;
  logic rst_ni;

  rtls_in_if  tick_if ();
  rtls_out_if result_if ();
  rtls_cfg_if reg_if ();

  run_to_line_sequencer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (result_if),
    .cfg_i  (reg_if)
  );

  pending_op_t  ops[$];
  tick_result_t expected_results[$];

  int unsigned ticks_sent;
  int unsigned results_seen;
  int unsigned queued_ticks;
  int unsigned cycle_count;
  int          errors;
  bit          tx_burst;
  bit          rx_quiet;

  // Sequencer state as the block should hold it
  rtls_pkg::cfg_t regs_m;
  logic [2:0]     seq_mode;
  logic [23:0]    seq_run_time;
  logic [15:0]    seq_black_time;
  logic [15:0]    seq_brake_left;
  logic [7:0]     seq_line_div;
  logic [7:0]     seq_speed_div;
  logic [1:0]     seq_drive;
  logic [9:0]     seq_fwd_speed;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stop driving, return the indicator command for the stop
  function automatic logic [2:0] halt_drive(logic faulted);
    seq_drive = rtls_pkg::DriveCoast;
    seq_mode  = faulted ? rtls_pkg::ModeFault : rtls_pkg::ModeIdle;
    return faulted ? rtls_pkg::IndFault : rtls_pkg::IndIdle;
  endfunction

  // Advance the sequencer by one 1 ms tick and form its result word
  function automatic tick_result_t advance_tick(rtls_pkg::in_word_t w);
    tick_result_t r;
    logic [3:0]   cnt;
    logic [2:0]   ind;
    logic         bal_rst;
    logic         step;
    logic [16:0]  bt;
    cnt     = (w.black_count > rtls_pkg::SensorCount) ? rtls_pkg::SensorCount
                                                      : w.black_count;
    ind     = rtls_pkg::IndNone;
    bal_rst = 1'b0;
    step    = 1'b0;

    // Button: stop an active run, otherwise start a new one
    if (w.button_pressed) begin
      if (seq_mode == rtls_pkg::ModeRunning || seq_mode == rtls_pkg::ModeBraking) begin
        ind = halt_drive(1'b0);
      end else begin
        seq_run_time   = '0;
        seq_black_time = '0;
        bal_rst        = 1'b1;
        seq_drive      = rtls_pkg::DriveForward;
        seq_fwd_speed  = (regs_m.base_speed_permille > rtls_pkg::MaxSpeed) ?
                         rtls_pkg::MaxSpeed : regs_m.base_speed_permille;
        ind            = rtls_pkg::IndStart;
        seq_mode       = rtls_pkg::ModeRunning;
      end
    end

    // Run timer or brake countdown
    if (seq_mode == rtls_pkg::ModeRunning) begin
      if (seq_run_time != rtls_pkg::RunTimeTop) seq_run_time = seq_run_time + 24'd1;
      if (seq_run_time >= regs_m.max_run_ms) ind = halt_drive(1'b1);
    end else if (seq_mode == rtls_pkg::ModeBraking) begin
      if (seq_brake_left != '0) seq_brake_left = seq_brake_left - 16'd1;
      if (seq_brake_left == '0) begin
        seq_drive = rtls_pkg::DriveCoast;
        seq_mode  = rtls_pkg::ModeFinished;
      end
    end

    // Line check once per control period
    seq_line_div = seq_line_div + 8'd1;
    if (seq_line_div >= regs_m.control_period_ms) begin
      seq_line_div = '0;
      if (!w.line_read_ok) begin
        if (seq_mode == rtls_pkg::ModeRunning) ind = halt_drive(1'b1);
      end else if (seq_mode != rtls_pkg::ModeRunning ||
                   seq_run_time < {8'd0, regs_m.start_guard_ms}) begin
        seq_black_time = '0;
      end else if (cnt >= regs_m.black_sensor_min) begin
        bt = {1'b0, seq_black_time} + {9'd0, regs_m.control_period_ms};
        seq_black_time = (bt > {1'b0, rtls_pkg::BlackTop}) ? rtls_pkg::BlackTop : bt[15:0];
        if (seq_black_time >= regs_m.black_confirm_ms) begin
          seq_drive      = rtls_pkg::DriveBrake;
          seq_brake_left = regs_m.brake_time_ms;
          seq_mode       = rtls_pkg::ModeBraking;
          ind            = rtls_pkg::IndFinished;
        end
      end else begin
        seq_black_time = '0;
      end
    end

    // Balancer step strobe, only while still running
    seq_speed_div = seq_speed_div + 8'd1;
    if (seq_speed_div >= regs_m.speed_period_ms) begin
      seq_speed_div = '0;
      if (seq_mode == rtls_pkg::ModeRunning) step = 1'b1;
    end

    r.run_state     = seq_mode;
    r.motor_enabled = (seq_drive != rtls_pkg::DriveCoast);
    r.motor_action  = seq_drive;
    r.drive_speed   = (seq_drive == rtls_pkg::DriveForward) ? seq_fwd_speed : 10'd0;
    r.balance_reset = bal_rst;
    r.balance_step  = step;
    r.indicator_cmd = ind;
    return r;
  endfunction

  // Register write as the block should apply it
  function automatic void write_model_reg(logic [7:0] idx, logic [23:0] data);
    case (idx)
      rtls_pkg::RegStartGuard:   regs_m.start_guard_ms      = data[15:0];
      rtls_pkg::RegMaxRun:       regs_m.max_run_ms          = data;
      rtls_pkg::RegBrakeTime:    regs_m.brake_time_ms       = data[15:0];
      rtls_pkg::RegBlackMin:     regs_m.black_sensor_min    = data[3:0];
      rtls_pkg::RegBlackConfirm: regs_m.black_confirm_ms    = data[15:0];
      rtls_pkg::RegControlPer:   regs_m.control_period_ms   = data[7:0];
      rtls_pkg::RegSpeedPer:     regs_m.speed_period_ms     = data[7:0];
      rtls_pkg::RegBaseSpeed:    regs_m.base_speed_permille = data[9:0];
      default: ;
    endcase
  endfunction

  task automatic queue_tick(logic btn, logic ok, logic [3:0] cnt);
    pending_op_t op;
    op.kind                = OpTick;
    op.word.button_pressed = btn;
    op.word.line_read_ok   = ok;
    op.word.black_count    = cnt;
    op.index               = '0;
    op.data                = '0;
    op.gap                 = tx_burst ? 0 : $urandom_range(0, 12);
    ops.push_back(op);
    queued_ticks++;
  endtask

  // Junk above the register width must be masked off by the block
  task automatic queue_reg(logic [7:0] idx, logic [23:0] val, int unsigned width);
    pending_op_t op;
    op.kind  = OpRegWrite;
    op.word  = '0;
    op.index = idx;
    op.data  = val;
    op.gap   = 0;
    if (width < 24 && $urandom_range(0, 2) == 0) op.data = op.data | (24'($urandom) << width);
    ops.push_back(op);
  endtask

  // Sender holds until every result word is back
  task automatic queue_settle();
    pending_op_t op;
    op.kind  = OpSettle;
    op.word  = '0;
    op.index = '0;
    op.data  = '0;
    op.gap   = 0;
    ops.push_back(op);
  endtask

  task automatic queue_noise(int unsigned len);
    for (int unsigned k = 0; k < len; k++)
      queue_tick($urandom_range(0, 7) == 0, $urandom_range(0, 5) != 0,
                 4'($urandom_range(0, 15)));
  endtask

  // Start, then stop by the button before anything resolves
  task automatic queue_abort(int unsigned len);
    queue_tick(1'b1, 1'b1, 4'($urandom_range(0, 15)));
    for (int unsigned k = 0; k < len; k++)
      queue_tick(1'b0, 1'b1, 4'($urandom_range(0, 15)));
    queue_tick(1'b1, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
  endtask

  // Start, then a string of failed sensor reads
  task automatic queue_fault_run(int unsigned len);
    queue_tick(1'b1, 1'b1, 4'($urandom_range(0, 15)));
    for (int unsigned k = 0; k < len; k++)
      queue_tick(1'b0, 1'b1, 4'($urandom_range(0, 15)));
    for (int unsigned k = 0; k < 3; k++)
      queue_tick(1'b0, 1'b0, 4'($urandom_range(0, 15)));
  endtask

  // Full run: guard stretch, black stretch long enough to confirm, then braking
  task automatic queue_run(int unsigned guard, int unsigned confirm, int unsigned ctrl,
                           int unsigned brake, int unsigned bmin);
    int unsigned pre;
    int unsigned on;
    int unsigned tail;
    logic [3:0]  cnt;
    pre  = guard + $urandom_range(0, 3);
    on   = confirm + 2 * (ctrl + 1) + $urandom_range(0, 4);
    tail = brake + $urandom_range(1, 4);
    queue_tick(1'b1, 1'b1, 4'($urandom_range(0, 15)));
    for (int unsigned k = 0; k < pre; k++)
      queue_tick(1'b0, $urandom_range(0, 29) != 0, 4'($urandom_range(0, 15)));
    for (int unsigned k = 0; k < on; k++) begin
      cnt = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(bmin, 15));
      queue_tick(1'b0, $urandom_range(0, 39) != 0, cnt);
    end
    for (int unsigned k = 0; k < tail; k++)
      queue_tick($urandom_range(0, 5) == 0, 1'b1, 4'($urandom_range(0, 15)));
  endtask

  // Input driver: ticks, register writes and settle points from the op queue
  int unsigned gap_left;
  int unsigned settle_cnt;

  always @(posedge clk_i) begin
    logic        tick_v;
    logic        reg_v;
    pending_op_t op;
    if (!rst_ni) begin
      tick_if.valid <= 1'b0;
      reg_if.valid  <= 1'b0;
      gap_left      = 0;
      settle_cnt    = 0;
    end else begin
      tick_v = tick_if.valid;
      reg_v  = reg_if.valid;
      if (tick_if.valid && tick_if.ready) begin
        expected_results.push_back(advance_tick({tick_if.button_pressed, tick_if.line_read_ok,
                                                 tick_if.black_count}));
        ticks_sent++;
        tick_v = 1'b0;
      end
      if (reg_if.valid && reg_if.ready) begin
        write_model_reg(reg_if.index, reg_if.data);
        reg_v = 1'b0;
      end
      if (!tick_v && !reg_v && ops.size() != 0) begin
        op = ops[0];
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (op.kind)
            OpTick: begin
              if (op.gap > 0) begin
                gap_left   = op.gap - 1;
                ops[0].gap = 0;
              end else begin
                tick_if.button_pressed <= op.word.button_pressed;
                tick_if.line_read_ok   <= op.word.line_read_ok;
                tick_if.black_count    <= op.word.black_count;
                tick_v = 1'b1;
                void'(ops.pop_front());
              end
            end
            OpRegWrite: begin
              reg_if.index <= op.index;
              reg_if.data  <= op.data;
              reg_v = 1'b1;
              void'(ops.pop_front());
            end
            default: begin
              if (ticks_sent == results_seen) begin
                settle_cnt++;
                if (settle_cnt >= SettleCycles) begin
                  settle_cnt = 0;
                  void'(ops.pop_front());
                end
              end else begin
                settle_cnt = 0;
              end
            end
          endcase
        end
      end
      tick_if.valid <= tick_v;
      reg_if.valid  <= reg_v;
    end
  end

  // Result receiver: random stalls per word, two long hold-offs
  int unsigned hold;
  int unsigned taken;

  always @(posedge clk_i) begin
    int unsigned h;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      hold  = 0;
      taken = 0;
    end else begin
      h = hold;
      if (result_if.valid && result_if.ready) begin
        taken++;
        if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
        if (taken == 120 || taken == 300) h = HoldCycles;
        else h = rx_quiet ? 0 : $urandom_range(0, 12);
      end else if (h > 0) begin
        h--;
      end
      hold = h;
      result_if.ready <= (h == 0);
    end
  end

  task automatic check_field(string name, logic [9:0] want, logic [9:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Monitor: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    tick_result_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("result word with no tick pending, run_state %0d", result_if.run_state);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("run_state", 10'(want.run_state), 10'(result_if.run_state));
        check_field("motor_enabled", 10'(want.motor_enabled), 10'(result_if.motor_enabled));
        check_field("motor_action", 10'(want.motor_action), 10'(result_if.motor_action));
        check_field("drive_speed", want.drive_speed, result_if.drive_speed);
        check_field("balance_reset", 10'(want.balance_reset), 10'(result_if.balance_reset));
        check_field("balance_step", 10'(want.balance_step), 10'(result_if.balance_step));
        check_field("indicator_cmd", 10'(want.indicator_cmd), 10'(result_if.indicator_cmd));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned guard;
    int unsigned maxrun;
    int unsigned brake;
    int unsigned bmin;
    int unsigned confirm;
    int unsigned ctrl;
    int unsigned spd;
    int unsigned base;
    int unsigned start_count;
    int unsigned r;

    clk_i                    = 1'b0;
    rst_ni                   = 1'b0;
    tick_if.valid            = 1'b0;
    tick_if.button_pressed   = 1'b0;
    tick_if.line_read_ok     = 1'b0;
    tick_if.black_count      = '0;
    result_if.ready          = 1'b0;
    reg_if.valid             = 1'b0;
    reg_if.index             = '0;
    reg_if.data              = '0;
    ticks_sent               = 0;
    results_seen             = 0;
    queued_ticks             = 0;
    cycle_count              = 0;
    errors                   = 0;
    tx_burst                 = 1'b0;
    rx_quiet                 = 1'b0;
    regs_m = '{start_guard_ms: 16'd500, max_run_ms: 24'd30000, brake_time_ms: 16'd300,
               black_sensor_min: 4'd3, black_confirm_ms: 16'd20, control_period_ms: 8'd5,
               speed_period_ms: 8'd10, base_speed_permille: 10'd300};
    seq_mode       = rtls_pkg::ModeIdle;
    seq_run_time   = '0;
    seq_black_time = '0;
    seq_brake_left = '0;
    seq_line_div   = '0;
    seq_speed_div  = '0;
    seq_drive      = rtls_pkg::DriveCoast;
    seq_fwd_speed  = '0;

    // Reset defaults: failed read and oversized count while idle, start, stop
    queue_tick(1'b0, 1'b0, 4'd15);
    queue_tick(1'b0, 1'b1, 4'd9);
    queue_tick(1'b1, 1'b1, 4'd0);
    queue_tick(1'b0, 1'b1, 4'd3);
    queue_tick(1'b1, 1'b1, 4'd8);

    // All zeros: timeout on the first running tick, speed above 1000 clamps
    queue_settle();
    queue_reg(rtls_pkg::RegStartGuard, 24'd0, 16);
    queue_reg(rtls_pkg::RegMaxRun, 24'd0, 24);
    queue_reg(rtls_pkg::RegBrakeTime, 24'd0, 16);
    queue_reg(rtls_pkg::RegBlackMin, 24'd0, 4);
    queue_reg(rtls_pkg::RegBlackConfirm, 24'd0, 16);
    queue_reg(rtls_pkg::RegControlPer, 24'd0, 8);
    queue_reg(rtls_pkg::RegSpeedPer, 24'd0, 8);
    queue_reg(rtls_pkg::RegBaseSpeed, 24'd1023, 10);
    queue_reg(RegPastEnd, 24'hFFFFFF, 24);
    queue_tick(1'b1, 1'b1, 4'd4);
    queue_tick(1'b0, 1'b1, 4'd4);
    queue_tick(1'b1, 1'b0, 4'd0);

    // Longest run limit: zero confirm arrives at once, zero brake lasts one tick
    queue_settle();
    queue_reg(rtls_pkg::RegMaxRun, 24'hFFFFFF, 24);
    queue_tick(1'b1, 1'b1, 4'd0);
    queue_tick(1'b0, 1'b1, 4'd0);
    queue_tick(1'b0, 1'b1, 4'd0);
    queue_tick(1'b1, 1'b1, 4'd2);
    queue_tick(1'b1, 1'b0, 4'd0);
    queue_tick(1'b1, 1'b0, 4'd0);

    // Guarded run to the line with all sensors black, braking to the finish, then a restart
    queue_settle();
    queue_reg(rtls_pkg::RegStartGuard, 24'd3, 16);
    queue_reg(rtls_pkg::RegMaxRun, 24'd100, 24);
    queue_reg(rtls_pkg::RegBrakeTime, 24'd3, 16);
    queue_reg(rtls_pkg::RegBlackMin, 24'hFFFFF8, 24);
    queue_reg(rtls_pkg::RegBlackConfirm, 24'd5, 16);
    queue_reg(rtls_pkg::RegControlPer, 24'd3, 8);
    queue_reg(rtls_pkg::RegSpeedPer, 24'd2, 8);
    queue_reg(rtls_pkg::RegBaseSpeed, 24'd0, 10);
    queue_tick(1'b1, 1'b1, 4'd15);
    for (int k = 0; k < 9; k++) queue_tick(1'b0, 1'b1, (k % 2 == 0) ? 4'd8 : 4'd15);
    queue_tick(1'b1, 1'b1, 4'd0);

    // Random phases, each under its own register setting
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      queue_settle();
      tx_burst = (ph % 3 == 1);
      guard    = $urandom_range(0, 8);
      maxrun   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(40, 90);
      brake    = $urandom_range(0, 6);
      bmin     = $urandom_range(0, 8);
      confirm  = $urandom_range(0, 10);
      ctrl     = $urandom_range(1, 3);
      spd      = $urandom_range(1, 12);
      base     = $urandom_range(0, 1023);
      if (ph == 2) begin
        ctrl = 0;
        spd  = 0;
      end
      if (ph == 5) begin
        guard   = 65535;
        maxrun  = 24'hFFFFFF;
        brake   = 65535;
        bmin    = 8;
        confirm = 65535;
        ctrl    = 255;
        spd     = 255;
        base    = 1000;
      end
      queue_reg(rtls_pkg::RegStartGuard, 24'(guard), 16);
      queue_reg(rtls_pkg::RegMaxRun, 24'(maxrun), 24);
      queue_reg(rtls_pkg::RegBrakeTime, 24'(brake), 16);
      queue_reg(rtls_pkg::RegBlackMin, 24'(bmin), 4);
      queue_reg(rtls_pkg::RegBlackConfirm, 24'(confirm), 16);
      queue_reg(rtls_pkg::RegControlPer, 24'(ctrl), 8);
      queue_reg(rtls_pkg::RegSpeedPer, 24'(spd), 8);
      queue_reg(rtls_pkg::RegBaseSpeed, 24'(base), 10);

      start_count = queued_ticks;
      while (queued_ticks - start_count < PhaseTicks) begin
        r = $urandom_range(0, 9);
        if (ph == 5) begin
          if (r < 5) queue_abort($urandom_range(1, 10));
          else if (r < 8) queue_fault_run($urandom_range(0, 6));
          else queue_noise($urandom_range(1, 6));
        end else if (r < 7) begin
          queue_run(guard, confirm, ctrl, brake, bmin);
        end else if (r == 7) begin
          queue_noise($urandom_range(1, 6));
        end else if (r == 8) begin
          queue_abort($urandom_range(1, 8));
        end else begin
          queue_fault_run($urandom_range(0, 6));
        end
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain, then allow for the pipeline before the verdict
    while (ops.size() != 0 || tick_if.valid || reg_if.valid || ticks_sent != results_seen)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected result words never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
